/* rtl/core/blob_header_seal_and_check_assert.svh */
// ----------------------------------------------------------------------------
// Blob header seal and check: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOB_HEADER_SEAL_AND_CHECK_ASSERT_SVH
`define BLOB_HEADER_SEAL_AND_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Delayed form: the consequent must hold after the antecedent.
`define BHSC_ASSERT_DLY3(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

/* rtl/core/bhsc_pkg.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: package
// Beat types, register map, header layout and CRC32C column constants.
// ----------------------------------------------------------------------------
package bhsc_pkg;

  localparam int HdrLength   = 48;
  localparam int HdrCrcSpan  = 44;
  localparam int HdrBits     = HdrCrcSpan * 8;
  localparam int CrcW        = 32;
  localparam int CrcLanes    = 4;
  localparam int LaneBits    = HdrBits / CrcLanes;
  localparam int PaddrW      = 5;

  localparam logic [CrcW-1:0] CrcPoly = 32'h82F63B78;
  localparam logic [CrcW-1:0] CrcOnes = 32'hFFFFFFFF;

  localparam logic [2:0] RegMagicWord     = 3'd0;
  localparam logic [2:0] RegFormatVersion = 3'd1;
  localparam logic [2:0] RegCodecNone     = 3'd2;
  localparam logic [2:0] RegCodecZstd     = 3'd3;
  localparam logic [2:0] RegZstdFlagMask  = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [63:0] blob_id;
    logic [63:0] plain_len;
    logic [63:0] packed_len;
    logic [31:0] codec;
    logic [31:0] content_crc;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_version;
    logic [15:0] hdr_length;
    logic [31:0] hdr_flags;
    logic [31:0] hdr_crc;
  } in_t;

  typedef struct packed {
    logic [31:0] header_crc;
    logic [31:0] flags_out;
    logic        header_ok;
  } out_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [31:0] codec_none_code;
    logic [31:0] codec_zstd_code;
    logic [31:0] zstd_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic               verify;
    logic               pre_ok;
    logic [CrcW-1:0]    hdr_crc;
    logic [31:0]        flags;
    logic [HdrBits-1:0] body;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef logic [HdrBits-1:0][CrcW-1:0] crc_col_t;

  function automatic logic [CrcW-1:0] crc_adv1(input logic [CrcW-1:0] c);
    return {1'b0, c[CrcW-1:1]} ^ (c[0] ? CrcPoly : '0);
  endfunction

  // Contribution of each header bit to the final CRC
  function automatic crc_col_t crc_cols();
    crc_col_t        cols;
    logic [CrcW-1:0] col;
    col = CrcPoly;
    for (int n = HdrBits - 1; n >= 0; n--) begin
      cols[n] = col;
      col     = crc_adv1(col);
    end
    return cols;
  endfunction

  // CRC of an all-zero header, initial value and final XOR included
  function automatic logic [CrcW-1:0] crc_fixed();
    logic [CrcW-1:0] c;
    c = CrcOnes;
    for (int n = 0; n < HdrBits; n++) begin
      c = crc_adv1(c);
    end
    return c ^ CrcOnes;
  endfunction

  localparam crc_col_t        CrcCol   = crc_cols();
  localparam logic [CrcW-1:0] CrcFixed = crc_fixed();

endpackage

/* rtl/core/bhsc_regs.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: configuration registers
// APB-style write and read access to the five header constants.
// ----------------------------------------------------------------------------
module bhsc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhsc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bhsc_pkg::cfg_t                cfg
);
  import bhsc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PaddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        RegMagicWord:     cfg_nxt.magic_word      = pwdata;
        RegFormatVersion: cfg_nxt.format_version  = pwdata[15:0];
        RegCodecNone:     cfg_nxt.codec_none_code = pwdata;
        RegCodecZstd:     cfg_nxt.codec_zstd_code = pwdata;
        RegZstdFlagMask:  cfg_nxt.zstd_flag_mask  = pwdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMagicWord:     prdata = cfg_r.magic_word;
      RegFormatVersion: prdata = {16'b0, cfg_r.format_version};
      RegCodecNone:     prdata = cfg_r.codec_none_code;
      RegCodecZstd:     prdata = cfg_r.codec_zstd_code;
      RegZstdFlagMask:  prdata = cfg_r.zstd_flag_mask;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word      <= '0;
      cfg_r.format_version  <= '0;
      cfg_r.codec_none_code <= '0;
      cfg_r.codec_zstd_code <= 32'd1;
      cfg_r.zstd_flag_mask  <= 32'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/bhsc_front.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: front end
// Accept a beat, select the header fields by mode and run the field checks.
// ----------------------------------------------------------------------------
module bhsc_front (
  input  logic              start,
  input  bhsc_pkg::in_t     in_data,
  input  bhsc_pkg::cfg_t    cfg,
  input  bhsc_pkg::q_stat_t q_stat,
  output logic              busy,
  output logic              push,
  output bhsc_pkg::job_t    job
);
  import bhsc_pkg::*;

  logic        verify;
  logic        is_zstd;
  logic        is_none;
  logic [31:0] magic;
  logic [15:0] version;
  logic [15:0] length;
  logic [31:0] flags;
  logic        fields_ok;

  assign busy = q_stat.full;
  assign push = start & ~q_stat.full;

  assign verify  = in_data.mode;
  assign is_zstd = (in_data.codec == cfg.codec_zstd_code);
  assign is_none = (in_data.codec == cfg.codec_none_code);

  assign magic   = verify ? in_data.hdr_magic   : cfg.magic_word;
  assign version = verify ? in_data.hdr_version : cfg.format_version;
  assign length  = verify ? in_data.hdr_length  : 16'(HdrLength);
  assign flags   = verify ? in_data.hdr_flags   : (is_zstd ? cfg.zstd_flag_mask : '0);

  assign fields_ok = (in_data.hdr_magic == cfg.magic_word)
                   & (in_data.hdr_version == cfg.format_version)
                   & (in_data.hdr_length == 16'(HdrLength))
                   & (is_none | is_zstd);

  assign job.verify  = verify;
  assign job.pre_ok  = ~verify | fields_ok;
  assign job.hdr_crc = in_data.hdr_crc;
  assign job.flags   = flags;
  assign job.body    = {in_data.content_crc, in_data.packed_len, in_data.plain_len,
                        in_data.blob_id, in_data.codec, flags, length, version, magic};

endmodule

/* rtl/core/bhsc_queue.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: job queue
// Two-entry queue between the front end and the CRC back end.
// ----------------------------------------------------------------------------
module bhsc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bhsc_pkg::job_t    wr_job,
  input  logic              pop,
  output bhsc_pkg::job_t    rd_job,
  output bhsc_pkg::q_stat_t q_stat
);
  import bhsc_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);
  assign do_pop       = pop & ~q_stat.empty;
  assign rd_job       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

/* rtl/core/bhsc_back.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: CRC back end
// Registered XOR tree over the header bits, CRC compare and result beat.
// ----------------------------------------------------------------------------
module bhsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bhsc_pkg::q_stat_t q_stat,
  input  bhsc_pkg::job_t    job,
  output logic              pop,
  output logic              out_valid,
  output bhsc_pkg::out_t    out_data
);
  import bhsc_pkg::*;

  logic [CrcLanes-1:0][CrcW-1:0] part_nxt;
  logic [CrcLanes-1:0][CrcW-1:0] part_r;
  logic                          s1_valid_r;
  logic                          s1_verify_r;
  logic                          s1_pre_ok_r;
  logic [CrcW-1:0]               s1_hdr_crc_r;
  logic [31:0]                   s1_flags_r;
  logic [CrcW-1:0]               crc;
  logic                          out_valid_r;
  out_t                          out_data_r;
  out_t                          out_data_nxt;

  assign pop = ~q_stat.empty;

  always_comb begin
    for (int l = 0; l < CrcLanes; l++) begin
      part_nxt[l] = '0;
      for (int k = 0; k < LaneBits; k++) begin
        part_nxt[l] = part_nxt[l] ^ (job.body[l*LaneBits + k] ? CrcCol[l*LaneBits + k] : '0);
      end
    end
  end

  always_comb begin
    crc = CrcFixed;
    for (int l = 0; l < CrcLanes; l++) begin
      crc = crc ^ part_r[l];
    end
    out_data_nxt.header_crc = crc;
    out_data_nxt.flags_out  = s1_flags_r;
    out_data_nxt.header_ok  = s1_pre_ok_r & (~s1_verify_r | (crc == s1_hdr_crc_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= pop;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    part_r       <= part_nxt;
    s1_verify_r  <= job.verify;
    s1_pre_ok_r  <= job.pre_ok;
    s1_hdr_crc_r <= job.hdr_crc;
    s1_flags_r   <= job.flags;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/blob_header_seal_and_check.sv */
// Pipeline: queue slot, registered XOR lanes and registered result; out_valid is
// registered alongside the result.
// Throughput: one header per cycle; the back end drains a queue beat every cycle, busy stays low.
// Reset: synchronous, active low; clears the queue, pipeline valids and registers
// (codec_zstd_code and zstd_flag_mask reset to 1, the others to 0).
// ----------------------------------------------------------------------------
// Blob header seal and check: top level
// Builds or verifies a CRC32C-sealed 48-byte blob header.
// ----------------------------------------------------------------------------
module blob_header_seal_and_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bhsc_pkg::in_t                 in_data,
  output logic                          out_valid,
  output bhsc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhsc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bhsc_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  job_t    wr_job;
  job_t    rd_job;
  logic    push;
  logic    pop;

  bhsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bhsc_front u_front (
    .start   (start),
    .in_data (in_data),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .job     (wr_job)
  );

  bhsc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  bhsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job       (rd_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/bhsc_checker.sv */
// ----------------------------------------------------------------------------
// Blob header seal and check: port checker
// Timing and result checks seen from the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
`include "blob_header_seal_and_check_assert.svh"

module bhsc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  bhsc_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  bhsc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhsc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready
);
  import bhsc_pkg::*;

  logic accept;
  logic build_accept;
  logic cfg_wr;
  logic magic_sel;

  assign accept       = start & ~busy;
  assign build_accept = accept & ~in_data.mode;
  assign magic_sel    = (paddr[PaddrW-1:2] == RegMagicWord);
  assign cfg_wr       = psel & penable & pwrite & pready & magic_sel;

  `BHSC_ASSERT_DLY3(a_accept_to_result, accept, out_valid, "accepted beat gave no result")
  `BHSC_ASSERT_IMPL(a_result_has_source, out_valid, $past(accept, 3), "result without beat")
  `BHSC_ASSERT_DLY3(a_build_ok, build_accept, out_data.header_ok, "build result not ok")
  `BHSC_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy with a non-stalling receiver")
  `BHSC_ASSERT_IMPL(a_magic_readback, $past(cfg_wr) & magic_sel, prdata == $past(pwdata), "magic write lost")

endmodule

bind blob_header_seal_and_check bhsc_checker u_bhsc_checker (.*);

/* dv/tb_blob_header_seal_and_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob header seal and check: testbench
// Drives build and verify commands through six register settings. A bit-serial
// CRC32C predictor forms each expected result, and every strobed result is
// compared field by field, in order, with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_blob_header_seal_and_check;
  import bhsc_pkg::*;

  localparam int StallLimit = 5000;

  class header_ledger;
    cfg_t regs;
    out_t due_results[$];
    int   n_errors;
    int   n_built;
    int   n_accepted;
    int   n_rejected;

    function new();
      regs                 = '0;
      regs.codec_zstd_code = 32'd1;
      regs.zstd_flag_mask  = 32'd1;
      n_errors             = 0;
      n_built              = 0;
      n_accepted           = 0;
      n_rejected           = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        RegMagicWord:     regs.magic_word      = v;
        RegFormatVersion: regs.format_version  = v[15:0];
        RegCodecNone:     regs.codec_none_code = v;
        RegCodecZstd:     regs.codec_zstd_code = v;
        RegZstdFlagMask:  regs.zstd_flag_mask  = v;
        default: ;
      endcase
    endfunction

    function out_t seal_header(in_t h);
      logic [HdrBits-1:0] body;
      logic [31:0]        magic;
      logic [31:0]        flags;
      logic [31:0]        c;
      logic [15:0]        version;
      logic [15:0]        length;
      logic               fb;
      out_t               r;
      if (h.mode) begin
        magic   = h.hdr_magic;
        version = h.hdr_version;
        length  = h.hdr_length;
        flags   = h.hdr_flags;
      end else begin
        magic   = regs.magic_word;
        version = regs.format_version;
        length  = 16'(HdrLength);
        flags   = (h.codec == regs.codec_zstd_code) ? regs.zstd_flag_mask : 32'd0;
      end
      body = {h.content_crc, h.packed_len, h.plain_len, h.blob_id, h.codec,
              flags, length, version, magic};
      c = CrcOnes;
      for (int n = 0; n < HdrBits; n++) begin
        fb = c[0] ^ body[n];
        c  = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      r.header_crc = c ^ CrcOnes;
      r.flags_out  = flags;
      r.header_ok  = !h.mode ||
                     (h.hdr_magic == regs.magic_word &&
                      h.hdr_version == regs.format_version &&
                      h.hdr_length == 16'(HdrLength) &&
                      (h.codec == regs.codec_none_code || h.codec == regs.codec_zstd_code) &&
                      r.header_crc == h.hdr_crc);
      return r;
    endfunction

    function void note_header(in_t h);
      out_t r;
      r = seal_header(h);
      if (!h.mode) n_built++;
      else if (r.header_ok) n_accepted++;
      else n_rejected++;
      due_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result crc=%h flags=%h ok=%b", $time,
                 got.header_crc, got.flags_out, got.header_ok);
        n_errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.header_crc !== want.header_crc) begin
        $display("%0t: header_crc expected %h actual %h", $time,
                 want.header_crc, got.header_crc);
        n_errors++;
      end
      if (got.flags_out !== want.flags_out) begin
        $display("%0t: flags_out expected %h actual %h", $time,
                 want.flags_out, got.flags_out);
        n_errors++;
      end
      if (got.header_ok !== want.header_ok) begin
        $display("%0t: header_ok expected %b actual %b", $time,
                 want.header_ok, got.header_ok);
        n_errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_data;
  logic              out_valid;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  header_ledger ledger = new();
  bit           steady;
  int           stall_cycles;

  blob_header_seal_and_check u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_header(in_t h);
    while (!steady && $urandom_range(99) < 32) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_data = h;
    do @(posedge clk); while (busy);
    ledger.note_header(h);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PaddrW'({idx, 2'b00});
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic in_t rand_fields();
    in_t h;
    h.mode        = 1'($urandom_range(1));
    h.blob_id     = {$urandom, $urandom};
    h.plain_len   = {$urandom, $urandom};
    h.packed_len  = {$urandom, $urandom};
    h.codec       = $urandom;
    h.content_crc = $urandom;
    h.hdr_magic   = $urandom;
    h.hdr_version = 16'($urandom);
    h.hdr_length  = 16'($urandom);
    h.hdr_flags   = $urandom;
    h.hdr_crc     = $urandom;
    return h;
  endfunction

  function automatic in_t reseal(in_t h);
    in_t r;
    r         = h;
    r.hdr_crc = ledger.seal_header(h).header_crc;
    return r;
  endfunction

  function automatic in_t good_check();
    in_t h;
    h             = rand_fields();
    h.mode        = 1'b1;
    h.hdr_magic   = ledger.regs.magic_word;
    h.hdr_version = ledger.regs.format_version;
    h.hdr_length  = 16'(HdrLength);
    h.codec       = $urandom_range(1) ? ledger.regs.codec_zstd_code
                                      : ledger.regs.codec_none_code;
    if ($urandom_range(1))
      h.hdr_flags = (h.codec == ledger.regs.codec_zstd_code) ? ledger.regs.zstd_flag_mask
                                                             : 32'd0;
    return reseal(h);
  endfunction

  function automatic in_t broken_check();
    in_t h;
    h = good_check();
    case ($urandom_range(5))
      0: h.hdr_magic   ^= 32'h1 << $urandom_range(31);
      1: h.hdr_version ^= 16'h1 << $urandom_range(15);
      2: begin
        h.hdr_length = 16'($urandom);
        if (h.hdr_length == 16'(HdrLength)) h.hdr_length = 16'(HdrLength + 1);
        h = reseal(h);
      end
      3: begin
        while (h.codec == ledger.regs.codec_none_code ||
               h.codec == ledger.regs.codec_zstd_code) h.codec = $urandom;
        h = reseal(h);
      end
      4: h.hdr_crc   ^= 32'h1 << $urandom_range(31);
      default: h.hdr_flags ^= 32'h1 << $urandom_range(31);
    endcase
    return h;
  endfunction

  function automatic in_t random_header();
    in_t h;
    int  pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      h      = rand_fields();
      h.mode = 1'b0;
      case ($urandom_range(2))
        0: h.codec = ledger.regs.codec_none_code;
        1: h.codec = ledger.regs.codec_zstd_code;
        default: ;
      endcase
    end else if (pick < 70) begin
      h = good_check();
    end else if (pick < 90) begin
      h = broken_check();
    end else begin
      h = rand_fields();
    end
    return h;
  endfunction

  task automatic run_phase(cfg_t c, int items, bit no_gaps, bit hold_midway);
    drain();
    write_reg(RegMagicWord, c.magic_word);
    write_reg(RegFormatVersion, {16'($urandom), c.format_version});
    write_reg(RegCodecNone, c.codec_none_code);
    write_reg(RegCodecZstd, c.codec_zstd_code);
    write_reg(RegZstdFlagMask, c.zstd_flag_mask);
    steady = no_gaps;
    for (int k = 0; k < items; k++) begin
      if (hold_midway && k == items / 2) drain();
      send_header(random_header());
    end
    steady = 1'b0;
  endtask

  initial begin
    in_t  h;
    in_t  z;
    cfg_t c;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    steady  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // build: zstd, none and an unknown codec, zero and all-ones fields
    h = '0;
    h.codec = 32'd1;
    send_header(h);
    h.codec = 32'd0;
    send_header(h);
    h = '1;
    h.mode = 1'b0;
    send_header(h);
    h.codec = 32'd1;
    send_header(h);

    // valid headers at both extremes
    z = '0;
    z.mode = 1'b1;
    z.hdr_length = 16'(HdrLength);
    z = reseal(z);
    send_header(z);
    h = '1;
    h.hdr_magic   = '0;
    h.hdr_version = '0;
    h.hdr_length  = 16'(HdrLength);
    h.codec       = 32'd1;
    send_header(reseal(h));

    // rejections: magic, version, length, codec, stored CRC, everything
    h = z; h.hdr_magic = 32'd1;            send_header(reseal(h));
    h = z; h.hdr_magic = '1;               send_header(reseal(h));
    h = z; h.hdr_version = 16'd1;          send_header(reseal(h));
    h = z; h.hdr_version = '1;             send_header(reseal(h));
    h = z; h.hdr_length = 16'd0;           send_header(reseal(h));
    h = z; h.hdr_length = 16'(HdrLength - 1); send_header(reseal(h));
    h = z; h.hdr_length = 16'(HdrLength + 1); send_header(reseal(h));
    h = z; h.hdr_length = '1;              send_header(reseal(h));
    h = z; h.codec = 32'd2;                send_header(reseal(h));
    h = z; h.codec = '1;                   send_header(reseal(h));
    h = z; h.hdr_crc ^= 32'h0000_0001;     send_header(h);
    h = z; h.hdr_crc ^= 32'h8000_0000;     send_header(h);
    h = '1;                                send_header(h);

    c = {$urandom, 16'($urandom), $urandom, $urandom, $urandom};
    run_phase(c, 115, 1'b0, 1'b0);
    c = '0;
    run_phase(c, 115, 1'b0, 1'b1);
    c = '1;
    run_phase(c, 115, 1'b0, 1'b0);
    c = {$urandom, 16'($urandom), $urandom, $urandom, $urandom};
    c.codec_none_code = c.codec_zstd_code;
    run_phase(c, 115, 1'b0, 1'b0);
    c = {$urandom, 16'($urandom), $urandom, $urandom, $urandom};
    run_phase(c, 115, 1'b1, 1'b0);
    c = {$urandom, 16'($urandom), 32'($urandom_range(3)), 32'($urandom_range(3)), $urandom};
    run_phase(c, 115, 1'b0, 1'b0);

    drain();
    $display("Run covered %0d builds and %0d checks (%0d valid, %0d rejected)",
             ledger.n_built, ledger.n_accepted + ledger.n_rejected,
             ledger.n_accepted, ledger.n_rejected);
    $display("over reset values and six register settings, extremes included");
    if (ledger.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bhsc_pkg.sv
rtl/core/bhsc_regs.sv
rtl/core/bhsc_front.sv
rtl/core/bhsc_queue.sv
rtl/core/bhsc_back.sv
rtl/core/blob_header_seal_and_check.sv
rtl/core/bhsc_checker.sv
dv/tb_blob_header_seal_and_check.sv
